>>> rtl/msc_pkg.sv
// Shared constants, types and table functions for the marching squares cell.
package msc_pkg;

	localparam int GRID_ROWS   = 1024;
	localparam int GRID_COLS   = 1024;
	localparam int FRAC_BITS   = 12;
	localparam int SAMPLE_BITS = 16;
	localparam int COORD_BITS  = 10;
	localparam int POS_BITS    = 23;

	localparam int DIFF_BITS = SAMPLE_BITS + 1;
	localparam int PROD_BITS = 2 * DIFF_BITS;
	localparam int QBITS     = FRAC_BITS + 1;
	localparam int NUM_BITS  = DIFF_BITS + QBITS;

	// Quotient bits resolved in each divider stage.
	localparam int S2_STEPS = QBITS / 3;
	localparam int S3_STEPS = QBITS / 3;
	localparam int S4_STEPS = QBITS - S2_STEPS - S3_STEPS;

	localparam logic [QBITS-1:0] FRAC_ONE = QBITS'(1) << FRAC_BITS;

	localparam logic [3:0] CASE_SADDLE_A = 4'd5;
	localparam logic [3:0] CASE_SADDLE_B = 4'd10;

	typedef enum logic [1:0] {
		EDGE_LEFT   = 2'd0,
		EDGE_BOTTOM = 2'd1,
		EDGE_RIGHT  = 2'd2,
		EDGE_TOP    = 2'd3
	} edge_t;

	typedef struct packed {
		logic [3:0]                      cs;
		logic [3:0][DIFF_BITS-1:0]       mag;
		logic [3:0][DIFF_BITS-1:0]       num;
		logic [3:0][DIFF_BITS-1:0]       den;
		logic [COORD_BITS-1:0]           row;
		logic [COORD_BITS-1:0]           col;
	} front_t;

	typedef struct packed {
		logic                        valid;
		logic [3:0]                  cs;
		logic [3:0][QBITS-1:0]       frac;
		logic [COORD_BITS-1:0]       row;
		logic [COORD_BITS-1:0]       col;
	} emit_in_t;

	// One restoring division step: returns {quotient bit, new remainder}.
	function automatic logic [DIFF_BITS:0] div_step(input logic [DIFF_BITS-1:0] r,
			input logic b, input logic [DIFF_BITS-1:0] d);
		logic [DIFF_BITS:0] t;
		logic [DIFF_BITS:0] dd;
		t  = {r, b};
		dd = {1'b0, d};
		if (t >= dd) begin
			return {1'b1, DIFF_BITS'(t - dd)};
		end
		return {1'b0, t[DIFF_BITS-1:0]};
	endfunction

	function automatic logic [2:0] edge_count(input logic [3:0] cs);
		case (cs)
			4'd0, 4'd15:                   return 3'd0;
			CASE_SADDLE_A, CASE_SADDLE_B:  return 3'd4;
			default:                       return 3'd2;
		endcase
	endfunction

	function automatic edge_t edge_at(input logic [3:0] cs, input logic [1:0] k);
		edge_t tbl [4];
		case (cs)
			4'd1:    tbl = '{EDGE_TOP, EDGE_LEFT, EDGE_LEFT, EDGE_LEFT};
			4'd2:    tbl = '{EDGE_LEFT, EDGE_BOTTOM, EDGE_LEFT, EDGE_LEFT};
			4'd3:    tbl = '{EDGE_TOP, EDGE_BOTTOM, EDGE_LEFT, EDGE_LEFT};
			4'd4:    tbl = '{EDGE_BOTTOM, EDGE_RIGHT, EDGE_LEFT, EDGE_LEFT};
			4'd5:    tbl = '{EDGE_LEFT, EDGE_BOTTOM, EDGE_RIGHT, EDGE_TOP};
			4'd6:    tbl = '{EDGE_LEFT, EDGE_RIGHT, EDGE_LEFT, EDGE_LEFT};
			4'd7:    tbl = '{EDGE_TOP, EDGE_RIGHT, EDGE_LEFT, EDGE_LEFT};
			4'd8:    tbl = '{EDGE_RIGHT, EDGE_TOP, EDGE_LEFT, EDGE_LEFT};
			4'd9:    tbl = '{EDGE_LEFT, EDGE_RIGHT, EDGE_LEFT, EDGE_LEFT};
			4'd10:   tbl = '{EDGE_LEFT, EDGE_TOP, EDGE_BOTTOM, EDGE_RIGHT};
			4'd11:   tbl = '{EDGE_RIGHT, EDGE_BOTTOM, EDGE_LEFT, EDGE_LEFT};
			4'd12:   tbl = '{EDGE_BOTTOM, EDGE_TOP, EDGE_LEFT, EDGE_LEFT};
			4'd13:   tbl = '{EDGE_BOTTOM, EDGE_LEFT, EDGE_LEFT, EDGE_LEFT};
			4'd14:   tbl = '{EDGE_LEFT, EDGE_TOP, EDGE_LEFT, EDGE_LEFT};
			default: tbl = '{EDGE_LEFT, EDGE_LEFT, EDGE_LEFT, EDGE_LEFT};
		endcase
		return tbl[k];
	endfunction

endpackage

>>> rtl/msc_if.sv
// Request channel interfaces for cell samples and crossing points.
interface msc_in_if;
	logic                                   valid;
	logic                                   ready;
	logic signed [msc_pkg::SAMPLE_BITS-1:0] corner_top_left;
	logic signed [msc_pkg::SAMPLE_BITS-1:0] corner_bottom_left;
	logic signed [msc_pkg::SAMPLE_BITS-1:0] corner_bottom_right;
	logic signed [msc_pkg::SAMPLE_BITS-1:0] corner_top_right;
	logic        [msc_pkg::COORD_BITS-1:0]  cell_row;
	logic        [msc_pkg::COORD_BITS-1:0]  cell_col;

	modport source (output valid, corner_top_left, corner_bottom_left, corner_bottom_right,
		corner_top_right, cell_row, cell_col, input ready);
	modport sink (input valid, corner_top_left, corner_bottom_left, corner_bottom_right,
		corner_top_right, cell_row, cell_col, output ready);
endinterface

interface msc_out_if;
	logic                              valid;
	logic                              ready;
	logic [msc_pkg::POS_BITS-1:0]      x_pos;
	logic [msc_pkg::POS_BITS-1:0]      y_pos;
	logic [1:0]                        edge_id;
	logic                              segment_end;
	logic                              last_point;

	modport source (output valid, x_pos, y_pos, edge_id, segment_end, last_point,
		input ready);
	modport sink (input valid, x_pos, y_pos, edge_id, segment_end, last_point,
		output ready);
endinterface

>>> rtl/msc_front.sv
// First stage: threshold compare, corner differences and position clamp.
module msc_front (
	input  logic                                   clk,
	input  logic                                   adv,
	input  logic signed [msc_pkg::SAMPLE_BITS-1:0] thr,
	input  logic signed [msc_pkg::SAMPLE_BITS-1:0] v0,
	input  logic signed [msc_pkg::SAMPLE_BITS-1:0] v1,
	input  logic signed [msc_pkg::SAMPLE_BITS-1:0] v2,
	input  logic signed [msc_pkg::SAMPLE_BITS-1:0] v3,
	input  logic        [msc_pkg::COORD_BITS-1:0]  row,
	input  logic        [msc_pkg::COORD_BITS-1:0]  col,
	output msc_pkg::front_t                        front_s1
);
	import msc_pkg::*;

	function automatic logic [DIFF_BITS-1:0] absdiff(input logic signed [SAMPLE_BITS-1:0] a,
			input logic signed [SAMPLE_BITS-1:0] b);
		logic signed [DIFF_BITS-1:0] x;
		x = DIFF_BITS'(a) - DIFF_BITS'(b);
		return x[DIFF_BITS-1] ? DIFF_BITS'(-x) : DIFF_BITS'(x);
	endfunction

	front_t nxt;

	always_comb begin
		nxt.cs  = {v3 >= thr, v2 >= thr, v1 >= thr, v0 >= thr};
		nxt.mag = {absdiff(v3, thr), absdiff(v2, thr), absdiff(v1, thr), absdiff(v0, thr)};
		// edges: left v0->v1, bottom v1->v2, right v3->v2, top v0->v3
		nxt.num = {absdiff(thr, v0), absdiff(thr, v3), absdiff(thr, v1), absdiff(thr, v0)};
		nxt.den = {absdiff(v3, v0), absdiff(v2, v3), absdiff(v2, v1), absdiff(v1, v0)};
		nxt.row = (int'(row) > GRID_ROWS - 1) ? COORD_BITS'(GRID_ROWS - 1) : row;
		nxt.col = (int'(col) > GRID_COLS - 1) ? COORD_BITS'(GRID_COLS - 1) : col;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			front_s1 <= nxt;
		end
	end

endmodule

>>> rtl/msc_decide.sv
// Saddle products and case swap for the ambiguous cells.
module msc_decide (
	input  logic                                    clk,
	input  logic                                    adv,
	input  logic [3:0]                              cs_s1,
	input  logic [3:0][msc_pkg::DIFF_BITS-1:0]      mag_s1,
	output logic [3:0]                              cs_s4
);
	import msc_pkg::*;

	logic [PROD_BITS-1:0] p02_s2, p13_s2;
	logic [3:0]           cs_s2, cs_s3;
	logic [3:0]           cs_fix;

	always_comb begin
		cs_fix = cs_s2;
		if (cs_s2 == CASE_SADDLE_A && p02_s2 < p13_s2) begin
			cs_fix = CASE_SADDLE_B;
		end else if (cs_s2 == CASE_SADDLE_B && p02_s2 > p13_s2) begin
			cs_fix = CASE_SADDLE_A;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p02_s2 <= PROD_BITS'(mag_s1[0]) * PROD_BITS'(mag_s1[2]);
			p13_s2 <= PROD_BITS'(mag_s1[1]) * PROD_BITS'(mag_s1[3]);
			cs_s2  <= cs_s1;
			cs_s3  <= cs_fix;
			cs_s4  <= cs_s3;
		end
	end

endmodule

>>> rtl/msc_div_lane.sv
// Pipelined restoring divider giving one rounded, clamped edge fraction.
module msc_div_lane (
	input  logic                            clk,
	input  logic                            adv,
	input  logic [msc_pkg::DIFF_BITS-1:0]   num,
	input  logic [msc_pkg::DIFF_BITS-1:0]   den,
	output logic [msc_pkg::QBITS-1:0]       frac
);
	import msc_pkg::*;

	logic [NUM_BITS-1:0]  dvd;
	logic [DIFF_BITS:0]   st2, st3, st4;
	logic [DIFF_BITS-1:0] r_c2, r_c3, r_c4;
	logic [QBITS-1:0]     q_c2, q_c3, q_c4;

	logic [DIFF_BITS-1:0] r_s2, r_s3, d_s2, d_s3;
	logic [QBITS-1:0]     q_s2, q_s3, q_s4, lo_s2, lo_s3;
	logic                 sat_s2, sat_s3, sat_s4, zero_s2, zero_s3, zero_s4;

	always_comb begin
		// add half the divisor for round to nearest
		dvd  = (NUM_BITS'(num) << FRAC_BITS) + NUM_BITS'(den >> 1);
		r_c2 = dvd[NUM_BITS-1:QBITS];
		q_c2 = '0;
		st2  = '0;
		for (int j = 0; j < S2_STEPS; j++) begin
			st2  = div_step(r_c2, dvd[QBITS-1-j], den);
			r_c2 = st2[DIFF_BITS-1:0];
			q_c2 = {q_c2[QBITS-2:0], st2[DIFF_BITS]};
		end
	end

	always_comb begin
		r_c3 = r_s2;
		q_c3 = q_s2;
		st3  = '0;
		for (int j = 0; j < S3_STEPS; j++) begin
			st3  = div_step(r_c3, lo_s2[QBITS-1-S2_STEPS-j], d_s2);
			r_c3 = st3[DIFF_BITS-1:0];
			q_c3 = {q_c3[QBITS-2:0], st3[DIFF_BITS]};
		end
	end

	always_comb begin
		r_c4 = r_s3;
		q_c4 = q_s3;
		st4  = '0;
		for (int j = 0; j < S4_STEPS; j++) begin
			st4  = div_step(r_c4, lo_s3[QBITS-1-S2_STEPS-S3_STEPS-j], d_s3);
			r_c4 = st4[DIFF_BITS-1:0];
			q_c4 = {q_c4[QBITS-2:0], st4[DIFF_BITS]};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			r_s2    <= r_c2;
			q_s2    <= q_c2;
			lo_s2   <= dvd[QBITS-1:0];
			d_s2    <= den;
			sat_s2  <= num > den;
			zero_s2 <= den == '0;
			r_s3    <= r_c3;
			q_s3    <= q_c3;
			lo_s3   <= lo_s2;
			d_s3    <= d_s2;
			sat_s3  <= sat_s2;
			zero_s3 <= zero_s2;
			q_s4    <= q_c4;
			sat_s4  <= sat_s3;
			zero_s4 <= zero_s3;
		end
	end

	assign frac = zero_s4 ? '0 : (sat_s4 ? FRAC_ONE : q_s4);

endmodule

>>> rtl/msc_emit.sv
// Output holding register that sends each cell's crossing points.
module msc_emit (
	input  logic              clk,
	input  logic              arst_n,
	input  msc_pkg::emit_in_t item,
	output logic              take,
	msc_out_if.source         points
);
	import msc_pkg::*;

	logic                      busy_q;
	logic [1:0]                k_q;
	logic [3:0]                cs_q;
	logic [3:0][QBITS-1:0]     frac_q;
	logic [COORD_BITS-1:0]     row_q, col_q;

	edge_t                     e;
	logic                      last;
	logic [QBITS-1:0]          fx, fy;

	always_comb begin
		e    = edge_at(cs_q, k_q);
		last = {1'b0, k_q} == edge_count(cs_q) - 3'd1;
		case (e)
			EDGE_LEFT: begin
				fx = '0;
				fy = frac_q[0];
			end
			EDGE_BOTTOM: begin
				fx = frac_q[1];
				fy = FRAC_ONE;
			end
			EDGE_RIGHT: begin
				fx = FRAC_ONE;
				fy = frac_q[2];
			end
			default: begin
				fx = frac_q[3];
				fy = '0;
			end
		endcase
	end

	assign take               = !busy_q || (points.ready && last);
	assign points.valid       = busy_q;
	assign points.x_pos       = (POS_BITS'(col_q) << FRAC_BITS) + POS_BITS'(fx);
	assign points.y_pos       = (POS_BITS'(row_q) << FRAC_BITS) + POS_BITS'(fy);
	assign points.edge_id     = e;
	assign points.segment_end = k_q[0];
	assign points.last_point  = last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			k_q    <= '0;
		end else if (take) begin
			// drop cells with no crossing
			busy_q <= item.valid && edge_count(item.cs) != 3'd0;
			k_q    <= '0;
		end else if (points.ready) begin
			k_q <= k_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cs_q   <= item.cs;
			frac_q <= item.frac;
			row_q  <= item.row;
			col_q  <= item.col;
		end
	end

endmodule

>>> rtl/marching_squares_cell.sv
// Marching squares cell: corner classify, saddle decide, edge divide, point emit.
// Path: a request is registered in stages s1 to s4, then in the emitter register.
// Throughput: one cell per cycle while the emitter is idle; else the pipeline stalls
// as the single output channel sends 2 or 4 points, one per cycle with ready high.
// Reset: arst_n clears the pipeline valid bits, the emitter and the threshold (to 0).
module marching_squares_cell (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic signed [msc_pkg::SAMPLE_BITS-1:0] cfg_wdata,
	msc_in_if.sink                                 samples,
	msc_out_if.source                              points
);
	import msc_pkg::*;

	logic signed [SAMPLE_BITS-1:0] thr_q;
	logic                          adv;
	logic                          v_s1, v_s2, v_s3, v_s4;
	front_t                        front_s1;
	logic [3:0]                    cs_s4;
	logic [3:0][QBITS-1:0]         frac_s4;
	logic [COORD_BITS-1:0]         row_s2, row_s3, row_s4, col_s2, col_s3, col_s4;
	emit_in_t                      item;

	assign samples.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= '0;
		end else if (cfg_we) begin
			thr_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= samples.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			row_s2 <= front_s1.row;
			row_s3 <= row_s2;
			row_s4 <= row_s3;
			col_s2 <= front_s1.col;
			col_s3 <= col_s2;
			col_s4 <= col_s3;
		end
	end

	msc_front u_front (
		.clk      (clk),
		.adv      (adv),
		.thr      (thr_q),
		.v0       (samples.corner_top_left),
		.v1       (samples.corner_bottom_left),
		.v2       (samples.corner_bottom_right),
		.v3       (samples.corner_top_right),
		.row      (samples.cell_row),
		.col      (samples.cell_col),
		.front_s1 (front_s1)
	);

	msc_decide u_decide (
		.clk    (clk),
		.adv    (adv),
		.cs_s1  (front_s1.cs),
		.mag_s1 (front_s1.mag),
		.cs_s4  (cs_s4)
	);

	for (genvar g = 0; g < 4; g++) begin : g_lane
		msc_div_lane u_lane (
			.clk  (clk),
			.adv  (adv),
			.num  (front_s1.num[g]),
			.den  (front_s1.den[g]),
			.frac (frac_s4[g])
		);
	end

	always_comb begin
		item.valid = v_s4;
		item.cs    = cs_s4;
		item.frac  = frac_s4;
		item.row   = row_s4;
		item.col   = col_s4;
	end

	msc_emit u_emit (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.take   (adv),
		.points (points)
	);

endmodule
